// ----- rtl/dq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg
// Operation and status codes, field widths and the per-operation result record
// shared by the double-ended queue modules.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int OP_W     = 2;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd1;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 2'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                pop_ok;
    logic [COUNT_W-1:0]  count;
  } dq_res_t;

endpackage

// ----- rtl/dq_ring.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ring
// Ring buffer core: head/tail/count registers and the entry memory. One
// operation per take; result record and read data are valid the next cycle.
// ----------------------------------------------------------------------------
module dq_ring #(
  parameter int DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   take,
  input  logic [dq_pkg::OP_W-1:0]   op,
  input  logic [dq_pkg::DATA_W-1:0] value,
  output dq_pkg::dq_res_t        res_r,
  output logic [dq_pkg::DATA_W-1:0] rd_data_r
);
  import dq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;

  logic [DATA_W-1:0] mem [DEPTH];

  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          wr_en;
  logic          full, empty;
  logic [XW-1:0] count_ext;
  dq_res_t       res_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign head_dec = (head_r == '0) ? AW'(DEPTH - 1) : head_r - 1'b1;
  assign tail_inc = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
  assign tail_dec = (tail_r == '0) ? AW'(DEPTH - 1) : tail_r - 1'b1;

  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    wr_en          = 1'b0;
    wr_addr        = tail_r;
    rd_addr        = head_r;
    res_nxt.status = ST_OK;
    res_nxt.pop_ok = 1'b0;
    unique case (op)
      OP_PUSH_BACK: begin
        if (full) begin
          res_nxt.status = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = tail_r;
          tail_nxt  = tail_inc;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          res_nxt.status = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = head_dec;
          head_nxt  = head_dec;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          res_nxt.status = ST_EMPTY;
        end else begin
          rd_addr        = tail_dec;
          tail_nxt       = tail_dec;
          count_nxt      = count_r - 1'b1;
          res_nxt.pop_ok = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          res_nxt.status = ST_EMPTY;
        end else begin
          rd_addr        = head_r;
          head_nxt       = head_inc;
          count_nxt      = count_r - 1'b1;
          res_nxt.pop_ok = 1'b1;
        end
      end
      default: ;
    endcase
    count_ext     = XW'(count_nxt);
    res_nxt.count = count_ext[COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else if (take) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && wr_en) begin
      mem[wr_addr] <= value;
    end
    if (take) begin
      rd_data_r <= mem[rd_addr];
      res_r     <= res_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("count above depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == tail_r))
    else $error("empty ring with head != tail");

  a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == CW'(DEPTH)) |-> (head_r == tail_r))
    else $error("full ring with head != tail");

  a_refused_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (take && res_nxt.status != ST_OK) |=> ($stable(count_r) && $stable(head_r)
      && $stable(tail_r)))
    else $error("refused operation changed state");

endmodule

// ----- rtl/double_ended_queue_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded double-ended queue of DEPTH signed 32-bit entries in a ring buffer.
// ----------------------------------------------------------------------------
// Takes one operation per cycle unless stalled (push back/front, pop
// back/front) and returns exactly one result per operation: status, popped
// value (zero unless a pop succeeded) and the entry count after the
// operation. Results pass through the entry memory's registered read and then
// the output register. Refused operations (push on full, pop on empty) leave
// the queue unchanged. entry_count is the count's low five bits.
module double_ended_queue_top #(
  parameter int DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [dq_pkg::OP_W-1:0]         in_operation,
  input  logic signed [dq_pkg::DATA_W-1:0] in_push_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dq_pkg::STATUS_W-1:0]     out_status,
  output logic signed [dq_pkg::DATA_W-1:0] out_popped_value,
  output logic [dq_pkg::COUNT_W-1:0]      out_entry_count
);
  import dq_pkg::*;

  logic              take;
  logic              s1_adv;
  logic              s1_valid_r, s1_valid_nxt;
  logic              out_valid_r, out_valid_nxt;
  dq_res_t           res;
  logic [DATA_W-1:0] rd_data;
  logic [STATUS_W-1:0] status_r;
  logic [DATA_W-1:0]   popped_r;
  logic [COUNT_W-1:0]  count_r;

  dq_ring #(
    .DEPTH (DEPTH)
  ) u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .op        (in_operation),
    .value     (in_push_value),
    .res_r     (res),
    .rd_data_r (rd_data)
  );

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign take     = in_valid && in_ready;

  assign s1_valid_nxt  = take || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      status_r <= res.status;
      popped_r <= res.pop_ok ? rd_data : '0;
      count_r  <= res.count;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_popped_value = popped_r;
  assign out_entry_count  = count_r;

endmodule

// ----- tb/double_ended_queue_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_checker
// Prediction and comparison for the double-ended queue.
// ----------------------------------------------------------------------------
// Watches the operation and result channels. Every operation transfer is run
// through a local copy of the ring buffer. The status, popped value and entry
// count it yields are queued. Every result transfer is compared field by field
// with the oldest queued result. The mismatch total and the number of results
// still outstanding are passed back to the test top.
module double_ended_queue_checker #(
  parameter int DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [dq_pkg::OP_W-1:0]     in_operation,
  input  logic [dq_pkg::DATA_W-1:0]   in_push_value,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [dq_pkg::STATUS_W-1:0] out_status,
  input  logic [dq_pkg::DATA_W-1:0]   out_popped_value,
  input  logic [dq_pkg::COUNT_W-1:0]  out_entry_count,
  output int                          error_count,
  output int                          pending_count
);
  import dq_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   popped;
    logic [COUNT_W-1:0]  count;
  } deque_result_t;

  logic [DATA_W-1:0] ring [DEPTH];
  int                front_idx;
  int                back_idx;
  int                fill_level;
  int                fail_total;
  deque_result_t     expected_results [$];

  function automatic deque_result_t apply_deque_op(logic [OP_W-1:0] op,
                                                   logic [DATA_W-1:0] value);
    deque_result_t r;
    r.status = ST_OK;
    r.popped = '0;
    case (op)
      OP_PUSH_BACK: begin
        if (fill_level >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ring[back_idx] = value;
          back_idx = (back_idx + 1) % DEPTH;
          fill_level++;
        end
      end
      OP_PUSH_FRONT: begin
        if (fill_level >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          front_idx = (front_idx == 0) ? DEPTH - 1 : front_idx - 1;
          ring[front_idx] = value;
          fill_level++;
        end
      end
      OP_POP_BACK: begin
        if (fill_level == 0) begin
          r.status = ST_EMPTY;
        end else begin
          back_idx = (back_idx == 0) ? DEPTH - 1 : back_idx - 1;
          r.popped = ring[back_idx];
          fill_level--;
        end
      end
      OP_POP_FRONT: begin
        if (fill_level == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped = ring[front_idx];
          front_idx = (front_idx + 1) % DEPTH;
          fill_level--;
        end
      end
    endcase
    r.count = fill_level[COUNT_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic [DATA_W-1:0] exp_val,
                                      logic [DATA_W-1:0] act_val);
    if (exp_val !== act_val) begin
      fail_total++;
      $error("%s mismatch: expected 0x%08h, actual 0x%08h", name, exp_val, act_val);
    end
  endfunction

  always @(posedge clk) begin : track
    deque_result_t want;
    if (!rst_n) begin
      front_idx  = 0;
      back_idx   = 0;
      fill_level = 0;
      expected_results.delete();
    end else begin
      // result side first: a result can never belong to a same-cycle operation
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          fail_total++;
          $error("result transfer with no operation outstanding");
        end else begin
          want = expected_results.pop_front();
          check_field("out_status", DATA_W'(want.status), DATA_W'(out_status));
          check_field("out_popped_value", want.popped, out_popped_value);
          check_field("out_entry_count", DATA_W'(want.count), DATA_W'(out_entry_count));
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(apply_deque_op(in_operation, in_push_value));
    end
    error_count   <= fail_total;
    pending_count <= expected_results.size();
  end

endmodule

// ----- tb/double_ended_queue_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_top_test
// Stimulus and verdict for the double-ended queue.
// ----------------------------------------------------------------------------
// A directed opening covers pops on an empty queue, pushes from both ends up
// to full (the first six extreme values), refused pushes and pops from both
// ends. Random segments then lean toward pushing, popping or neither. This
// drives the queue through full, empty and pointer wrap many times. The
// sender works in bursts with random gaps. The receiver stalls in modes of
// its own. A checker beside the block predicts and compares every transfer.
module double_ended_queue_top_test;
  import dq_pkg::*;

  localparam int RANDOM_OPS = 1000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     in_operation = OP_PUSH_BACK;
  logic [DATA_W-1:0]   in_push_value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [DATA_W-1:0]   out_popped_value;
  logic [COUNT_W-1:0]  out_entry_count;
  int                  error_count;
  int                  pending_count;

  int                  burst_left = 0;
  int                  stall_mode = 0;
  int                  stall_left = 0;

  double_ended_queue_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_popped_value (out_popped_value),
    .out_entry_count  (out_entry_count)
  );

  double_ended_queue_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_popped_value (out_popped_value),
    .out_entry_count  (out_entry_count),
    .error_count      (error_count),
    .pending_count    (pending_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic send_op(logic [OP_W-1:0] op, logic [DATA_W-1:0] value);
    int gap;
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_push_value <= value;
    do @(posedge clk); while (!in_ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 31);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [DATA_W-1:0] corner_values [6];
    logic [OP_W-1:0]   op;
    int                push_pct;
    int                seg_left;
    corner_values = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
                      32'hffff_ffff, 32'haaaa_aaaa, 32'h5555_5555};
    push_pct = 50;
    seg_left = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty pops, fill from both ends, refused pushes, pops from both ends
    send_op(OP_POP_BACK, 32'h1234_5678);
    send_op(OP_POP_FRONT, 32'hffff_ffff);
    for (int i = 0; i < 16; i++)
      send_op((i % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK,
              (i < 6) ? corner_values[i] : $urandom());
    send_op(OP_PUSH_BACK, 32'hdead_beef);
    send_op(OP_PUSH_FRONT, 32'h0bad_f00d);
    send_op(OP_POP_FRONT, 32'h0);
    send_op(OP_POP_BACK, 32'h0);

    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (seg_left == 0) begin
        case ($urandom_range(0, 2))
          0: push_pct = 85;
          1: push_pct = 15;
          default: push_pct = 50;
        endcase
        seg_left = $urandom_range(20, 60);
      end
      seg_left--;
      if ($urandom_range(0, 99) < push_pct)
        op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      else
        op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
      send_op(op, pick_value());
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0 && pending_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
